/* rtl/core/fas_pkg.sv */
// Shared types and constants of the frame animation sequencer.
package fas_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_RANGE = 2'd1;
  localparam logic [1:0] KIND_SEQ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  localparam logic [31:0] LCG_MUL  = 32'd1664525;
  localparam logic [31:0] LCG_ADD  = 32'd1013904223;
  localparam logic [31:0] RNG_SEED = 32'h12345678;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  anim;
    logic [4:0]  index_or_count;
    logic [15:0] pic;
    logic [15:0] end_pic;
    logic        random_tics;
    logic [15:0] dur_lo;
    logic [15:0] dur_hi;
    logic [1:0]  anim_kind;
    logic        oscillate;
    logic        animate;
  } in_t;

  typedef struct packed {
    logic [15:0] picture;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [15:0] pic;
    logic        rnd;
    logic [15:0] tmin;
    logic [15:0] tmax;
  } frame_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  count;
    logic        osc;
    logic [15:0] rstart;
    logic [15:0] rend;
    logic [15:0] rtics;
    logic [4:0]  pos;
    logic [15:0] left;
    logic        dir;
  } chan_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
    logic [16:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_QDIV1, S_QDIV2, S_QMEM, S_TCH, S_TLOAD, S_TDIV, S_TSTEP
  } state_e;

endpackage

/* rtl/core/fas_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module fas_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fas_pkg::div_req_t req_i,
  output fas_pkg::div_rsp_t rsp_o
);
  import fas_pkg::*;

  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [31:0] q_q, q_d;
  logic [16:0] r_q, r_d, d_q, d_d;
  logic [17:0] shifted, trial;

  always_comb begin
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    q_d     = q_q;
    r_d     = r_q;
    d_d     = d_q;
    shifted = {r_q, q_q[31]};
    trial   = shifted - {1'b0, d_q};
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      q_d    = req_i.dividend;
      r_d    = '0;
      d_d    = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[17]) begin
        r_d = trial[16:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = shifted[16:0];
        q_d = {q_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quot: q_q, rem: r_q};
endmodule

/* rtl/core/fas_frame_ram.sv */
// Frame table memory, one write and one registered read port.
module fas_frame_ram #(
  parameter int AW = 9
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  fas_pkg::frame_t     wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output fas_pkg::frame_t     rdata_o
);
  import fas_pkg::*;

  frame_t mem [2**AW];
  frame_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/core/frame_animation_sequencer.sv */
// Top level of the frame animation sequencer: control sequencer and channel state.
// Write and set answer from decode; a sequence query reads the frame table; an
// animated range query runs two serial divides; a tick visits each channel and
// divides for random draws. One word at a time; shared divider sets long cases.
// Reset: channels cleared to none, dir forward, LCG seeded, tick count zero;
// frame table contents undefined until written.
module frame_animation_sequencer #(
  parameter int MAX_ANIMS  = 32,
  parameter int MAX_FRAMES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fas_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fas_pkg::out_t out_data_o
);
  import fas_pkg::*;

  localparam int NCH = (MAX_ANIMS < 32) ? MAX_ANIMS : 32;
  localparam int NFR = (MAX_FRAMES < 32) ? MAX_FRAMES : 32;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int FW  = (NFR > 1) ? $clog2(NFR) : 1;
  localparam int AW  = CW + FW;
  localparam logic [CW-1:0] LAST_CH = CW'(NCH - 1);

  state_e      state_q, state_d;
  in_t         req_q, req_d;
  logic [CW-1:0] ch_q, ch_d;
  logic [31:0] tick_q, tick_d, rng_q, rng_d;
  logic [4:0]  p_q, p_d;
  logic [15:0] t_q, t_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  chan_t       chan_q [NCH];
  chan_t       cur, cw_data;
  logic        cw_en;

  div_req_t    dreq;
  div_rsp_t    drsp;

  logic        mwe, mre;
  logic [AW-1:0] mwaddr, mraddr;
  frame_t      mwdata, mrdata;

  logic [4:0]  pn;
  logic [15:0] hi, tl, ln;
  logic [16:0] nn, dd, fr;
  logic        dir_n;
  logic [5:0]  pw;

  fas_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  fas_frame_ram #(.AW(AW)) u_ram (
    .clk_i, .we_i(mwe), .waddr_i(mwaddr), .wdata_i(mwdata),
    .re_i(mre), .raddr_i(mraddr), .rdata_o(mrdata)
  );

  assign cur         = chan_q[ch_q];
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    ch_d        = ch_q;
    tick_d      = tick_q;
    rng_d       = rng_q;
    p_d         = p_q;
    t_d         = t_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cw_en       = 1'b0;
    cw_data     = cur;
    dreq        = '0;
    mwe         = 1'b0;
    mre         = 1'b0;
    mwaddr      = {ch_q, req_q.index_or_count[FW-1:0]};
    mraddr      = {ch_q, p_q[FW-1:0]};
    mwdata      = '{pic: req_q.pic, rnd: req_q.random_tics, tmin: req_q.dur_lo,
                    tmax: req_q.random_tics ? req_q.dur_hi : req_q.dur_lo};
    pn          = (cur.pos >= cur.count) ? 5'd0 : cur.pos;
    hi          = (mrdata.tmax < mrdata.tmin) ? mrdata.tmin : mrdata.tmax;
    tl          = mrdata.tmin + drsp.rem[15:0];
    ln          = t_q - 16'd1;
    nn          = {1'b0, cur.rend - cur.rstart} + 17'd1;
    dd          = {cur.rend - cur.rstart, 1'b0};
    fr          = drsp.rem;
    dir_n       = cur.dir;
    pw          = {1'b0, p_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          req_d   = in_data_i;
          ch_d    = (in_data_i.cmd == CMD_TICK) ? '0 : in_data_i.anim[CW-1:0];
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_IDLE;
        out_d   = '{picture: 16'd0, status: ST_OK};
        if (req_q.cmd == CMD_TICK) begin
          tick_d  = tick_q + 32'd1;
          state_d = S_TCH;
        end else if (32'(req_q.anim) >= MAX_ANIMS) begin
          out_d.status = ST_INACTIVE;
          out_valid_d  = 1'b1;
        end else if (req_q.cmd == CMD_WRITE) begin
          out_valid_d = 1'b1;
          if (32'(req_q.index_or_count) >= MAX_FRAMES || req_q.dur_lo == 16'd0 ||
              (req_q.random_tics && req_q.dur_hi < req_q.dur_lo)) begin
            out_d.status = ST_REJECT;
          end else begin
            mwe = 1'b1;
          end
        end else if (req_q.cmd == CMD_SET) begin
          out_valid_d = 1'b1;
          cw_data     = '{kind: KIND_NONE, count: 5'd0, osc: 1'b0, rstart: 16'd0,
                          rend: 16'd0, rtics: 16'd0, pos: 5'd0, left: 16'd0, dir: 1'b1};
          if (req_q.anim_kind == KIND_SEQ) begin
            if (req_q.index_or_count == 5'd0 || 32'(req_q.index_or_count) > MAX_FRAMES) begin
              out_d.status = ST_REJECT;
            end else begin
              cw_en         = 1'b1;
              cw_data.kind  = KIND_SEQ;
              cw_data.count = req_q.index_or_count;
              cw_data.osc   = req_q.oscillate;
            end
          end else if (req_q.anim_kind == KIND_RANGE) begin
            cw_en          = 1'b1;
            cw_data.kind   = KIND_RANGE;
            cw_data.rstart = req_q.pic;
            cw_data.rend   = req_q.end_pic;
            cw_data.rtics  = req_q.dur_lo;
            cw_data.osc    = req_q.oscillate;
          end else begin
            cw_en = 1'b1;
          end
        end else begin
          if (cur.kind == KIND_RANGE) begin
            out_d.picture = cur.rstart;
            if (cur.rstart >= cur.rend || cur.rtics == 16'd0) begin
              out_d.status = ST_RANGE;
              out_valid_d  = 1'b1;
            end else if (!req_q.animate) begin
              out_valid_d = 1'b1;
            end else begin
              dreq    = '{start: 1'b1, dividend: tick_q, divisor: {1'b0, cur.rtics}};
              state_d = S_QDIV1;
            end
          end else if (cur.kind == KIND_SEQ && cur.count != 5'd0) begin
            p_d     = req_q.animate ? pn : 5'd0;
            mraddr  = {ch_q, p_d[FW-1:0]};
            mre     = 1'b1;
            state_d = S_QMEM;
          end else begin
            out_d.status = ST_INACTIVE;
            out_valid_d  = 1'b1;
          end
        end
      end
      S_QDIV1: begin
        if (drsp.done) begin
          dreq    = '{start: 1'b1, dividend: drsp.quot, divisor: cur.osc ? dd : nn};
          state_d = S_QDIV2;
        end
      end
      S_QDIV2: begin
        if (drsp.done) begin
          if (cur.osc && fr >= nn) begin
            fr = dd - fr;
          end
          out_d       = '{picture: cur.rstart + fr[15:0], status: ST_OK};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_QMEM: begin
        out_d       = '{picture: mrdata.pic, status: ST_OK};
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_TCH: begin
        if (cur.kind != KIND_SEQ || cur.count == 5'd0) begin
          if (ch_q == LAST_CH) begin
            out_d       = '{picture: 16'd0, status: ST_OK};
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            ch_d = ch_q + CW'(1);
          end
        end else begin
          p_d = pn;
          if (cur.left == 16'd0) begin
            mraddr  = {ch_q, pn[FW-1:0]};
            mre     = 1'b1;
            state_d = S_TLOAD;
          end else begin
            t_d     = cur.left;
            state_d = S_TSTEP;
          end
        end
      end
      S_TLOAD: begin
        if (!mrdata.rnd || hi <= mrdata.tmin) begin
          if (mrdata.rnd) begin
            rng_d = rng_q * LCG_MUL + LCG_ADD;
          end
          t_d     = (mrdata.tmin == 16'd0) ? 16'd1 : mrdata.tmin;
          state_d = S_TSTEP;
        end else begin
          rng_d   = rng_q * LCG_MUL + LCG_ADD;
          dreq    = '{start: 1'b1, dividend: rng_d,
                      divisor: {1'b0, hi - mrdata.tmin} + 17'd1};
          state_d = S_TDIV;
        end
      end
      S_TDIV: begin
        if (drsp.done) begin
          t_d     = (tl == 16'd0) ? 16'd1 : tl;
          state_d = S_TSTEP;
        end
      end
      S_TSTEP: begin
        if (ln == 16'd0) begin
          if (cur.osc && cur.count > 5'd1) begin
            if (cur.dir && pw >= {1'b0, cur.count} - 6'd1) begin
              dir_n = 1'b0;
            end else if (!cur.dir && p_q == 5'd0) begin
              dir_n = 1'b1;
            end
            pw = dir_n ? pw + 6'd1 : pw - 6'd1;
          end else begin
            pw = pw + 6'd1;
            if (pw >= {1'b0, cur.count}) begin
              pw = 6'd0;
            end
          end
        end
        cw_en        = 1'b1;
        cw_data.left = ln;
        cw_data.pos  = pw[4:0];
        cw_data.dir  = dir_n;
        if (ch_q == LAST_CH) begin
          out_d       = '{picture: 16'd0, status: ST_OK};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          ch_d    = ch_q + CW'(1);
          state_d = S_TCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      rng_q       <= RNG_SEED;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
      for (int i = 0; i < NCH; i++) begin
        chan_q[i] <= '{kind: KIND_NONE, count: 5'd0, osc: 1'b0, rstart: 16'd0,
                       rend: 16'd0, rtics: 16'd0, pos: 5'd0, left: 16'd0, dir: 1'b1};
      end
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      rng_q       <= rng_d;
      out_valid_q <= out_valid_d;
      ch_q        <= ch_d;
      if (cw_en) begin
        chan_q[ch_q] <= cw_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    p_q   <= p_d;
    t_q   <= t_d;
    out_q <= out_d;
  end

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp.busy) else $error("divider restarted while busy");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q != S_IDLE)) else $error("spurious result");
  a_tick_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_q != $past(tick_q)) |-> $past(state_q == S_DEC)) else $error("stray tick");
endmodule

/* sim/tb.sv */
// Frame animation sequencer bench: directed and random words checked by a predictor.
`timescale 1ns / 1ps

module tb;
  import fas_pkg::*;

  localparam int NCH = 32;
  localparam int NFR = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  frame_animation_sequencer dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  frame_t      frames [NCH][NFR];
  bit          written [NCH][NFR];
  logic [1:0]  kind [NCH];
  logic [4:0]  count [NCH];
  logic        osc [NCH];
  logic [15:0] rs [NCH], re [NCH], rt [NCH];
  int unsigned pos [NCH];
  logic [31:0] left [NCH];
  logic        dir [NCH];
  logic [31:0] rng;
  logic [31:0] ticks;

  in_t  pending [$];
  out_t expected [$];
  int   errors = 0;
  int   accepted = 0;
  int   hold_off = 0;
  int   burst = 0;
  int   gap = 0;
  bit   stim_done = 0;
  bit   pause_send = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void clear_chan(input int c);
    kind[c] = KIND_NONE; count[c] = 0; osc[c] = 0;
    rs[c] = 0; re[c] = 0; rt[c] = 0;
    pos[c] = 0; left[c] = 0; dir[c] = 1;
  endfunction

  function automatic logic [31:0] draw(input frame_t f);
    logic [31:0] hi;
    if (!f.rnd) return f.tmin;
    hi = (f.tmax < f.tmin) ? f.tmin : f.tmax;
    rng = rng * LCG_MUL + LCG_ADD;
    if (hi <= f.tmin) return f.tmin;
    return f.tmin + rng % (hi - f.tmin + 1);
  endfunction

  function automatic void step_chan(input int c);
    int unsigned n, p;
    logic [31:0] t;
    n = count[c];
    p = pos[c];
    if (kind[c] != KIND_SEQ || n == 0) return;
    if (p >= n) p = 0;
    if (left[c] == 0) begin
      t = draw(frames[c][p]);
      left[c] = (t == 0) ? 1 : t;
    end
    left[c]--;
    if (left[c] == 0) begin
      if (osc[c] && n > 1) begin
        if (dir[c] && p >= n - 1) dir[c] = 0;
        else if (!dir[c] && p == 0) dir[c] = 1;
        p = dir[c] ? p + 1 : p - 1;
      end else begin
        p++;
        if (p >= n) p = 0;
      end
    end
    pos[c] = p;
  endfunction

  function automatic out_t predict_word(input in_t w);
    out_t r;
    int c;
    logic [31:0] s, e, t, n, d, fr;
    r = '0;
    c = w.anim;
    if (w.cmd == CMD_TICK) begin
      ticks++;
      for (int i = 0; i < NCH; i++) step_chan(i);
    end else if (c >= NCH) begin
      r.status = ST_INACTIVE;
    end else if (w.cmd == CMD_WRITE) begin
      if (w.index_or_count >= NFR || w.dur_lo == 0 ||
          (w.random_tics && w.dur_hi < w.dur_lo)) begin
        r.status = ST_REJECT;
      end else begin
        frames[c][w.index_or_count] = '{w.pic, w.random_tics, w.dur_lo,
            w.random_tics ? w.dur_hi : w.dur_lo};
        written[c][w.index_or_count] = 1;
      end
    end else if (w.cmd == CMD_SET) begin
      if (w.anim_kind == KIND_SEQ) begin
        if (w.index_or_count == 0 || w.index_or_count > NFR) begin
          r.status = ST_REJECT;
        end else begin
          clear_chan(c);
          kind[c] = KIND_SEQ; count[c] = w.index_or_count; osc[c] = w.oscillate;
        end
      end else if (w.anim_kind == KIND_RANGE) begin
        clear_chan(c);
        kind[c] = KIND_RANGE; rs[c] = w.pic; re[c] = w.end_pic;
        rt[c] = w.dur_lo; osc[c] = w.oscillate;
      end else begin
        clear_chan(c);
      end
    end else begin
      if (kind[c] == KIND_RANGE) begin
        s = {16'd0, rs[c]}; e = {16'd0, re[c]}; t = {16'd0, rt[c]};
        if (s >= e || t == 0) begin
          r.picture = s[15:0]; r.status = ST_RANGE;
        end else if (!w.animate) begin
          r.picture = s[15:0];
        end else begin
          n = e - s + 1;
          if (osc[c]) begin
            d = 2 * (n - 1);
            fr = (ticks / t) % d;
            if (fr >= n) fr = d - fr;
          end else begin
            fr = (ticks / t) % n;
          end
          r.picture = 16'(s + fr);
        end
      end else if (kind[c] == KIND_SEQ && count[c] > 0) begin
        r.picture = (!w.animate || pos[c] >= count[c]) ? frames[c][0].pic
                                                        : frames[c][pos[c]].pic;
      end else begin
        r.status = ST_INACTIVE;
      end
    end
    return r;
  endfunction

  function automatic in_t rand_word();
    in_t w;
    w = '0;
    w.cmd = 2'($urandom_range(0, 3));
    w.anim = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
    w.index_or_count = ($urandom_range(0, 7) == 0) ? 5'($urandom)
                                                    : 5'($urandom_range(0, 15));
    w.pic = 16'($urandom);
    w.end_pic = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                             : 16'(w.pic + $urandom_range(0, 20));
    w.random_tics = 1'($urandom);
    w.dur_lo = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    w.dur_hi = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                            : 16'(w.dur_lo + $urandom_range(0, 8));
    w.anim_kind = 2'($urandom);
    w.oscillate = 1'($urandom);
    w.animate = 1'($urandom);
    return w;
  endfunction

  // keep sequences inside written slots
  function automatic in_t legalize(input in_t w);
    int n;
    if (w.cmd == CMD_SET && w.anim_kind == KIND_SEQ && w.anim < NCH) begin
      n = 0;
      while (n < NFR && written[w.anim][n]) n++;
      if (w.index_or_count > n && w.index_or_count <= NFR) begin
        w.cmd = CMD_WRITE;
        w.index_or_count = 5'(n);
        if (w.dur_lo == 0) w.dur_lo = 16'd1;
        if (w.random_tics && w.dur_hi < w.dur_lo) w.dur_hi = w.dur_lo;
      end
    end
    return w;
  endfunction

  function automatic in_t mk(input logic [1:0] cmd, input logic [4:0] a, input logic [4:0] ic,
                             input logic [15:0] p, input logic [15:0] ep, input logic rnd,
                             input logic [15:0] tmin, input logic [15:0] tmax,
                             input logic [1:0] k, input logic o, input logic an);
    return '{cmd, a, ic, p, ep, rnd, tmin, tmax, k, o, an};
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected.push_back(predict_word(in_data_i));
        accepted++;
      end
      if (in_valid_i && !in_ready_o) begin
      end else if (pause_send || pending.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_valid_i <= 1'b0;
      end else begin
        in_data_i <= legalize(pending.pop_front());
        in_valid_i <= 1'b1;
        if (burst <= 1) begin
          burst <= $urandom_range(1, 30);
          gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
        end else begin
          burst <= burst - 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected.size() == 0) begin
          report("word with nothing expected");
        end else begin
          if (out_data_o.picture !== expected[0].picture)
            report($sformatf("picture %0d want %0d", out_data_o.picture,
                             expected[0].picture));
          if (out_data_o.status !== expected[0].status)
            report($sformatf("status %0d want %0d", out_data_o.status,
                             expected[0].status));
          void'(expected.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else if (accepted > 300 && accepted < 330) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    for (int c = 0; c < NCH; c++) clear_chan(c);
    rng = RNG_SEED;
    ticks = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pending.push_back(mk(CMD_WRITE, 0, 0, 16'hFFFF, 0, 0, 16'hFFFF, 0, 0, 0, 0));
    pending.push_back(mk(CMD_WRITE, 0, 1, 16'h0001, 0, 1, 1, 3, 0, 0, 0));
    pending.push_back(mk(CMD_WRITE, 0, 2, 16'h0002, 0, 1, 4, 4, 0, 0, 0));
    pending.push_back(mk(CMD_WRITE, 0, 3, 5, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(CMD_WRITE, 0, 3, 5, 0, 1, 5, 4, 0, 0, 0));
    pending.push_back(mk(CMD_WRITE, 0, 16, 5, 0, 0, 1, 0, 0, 0, 0));
    pending.push_back(mk(CMD_WRITE, 31, 31, 5, 0, 1, 1, 16'hFFFF, 3, 1, 1));
    pending.push_back(mk(CMD_SET, 0, 3, 0, 0, 0, 0, 0, KIND_SEQ, 1, 0));
    pending.push_back(mk(CMD_SET, 1, 0, 0, 0, 0, 0, 0, KIND_SEQ, 0, 0));
    pending.push_back(mk(CMD_SET, 1, 17, 0, 0, 0, 0, 0, KIND_SEQ, 0, 0));
    pending.push_back(mk(CMD_SET, 2, 0, 10, 20, 0, 2, 0, KIND_RANGE, 0, 0));
    pending.push_back(mk(CMD_SET, 3, 0, 16'hFFF0, 16'hFFFF, 0, 1, 0, KIND_RANGE, 1, 0));
    pending.push_back(mk(CMD_SET, 4, 0, 9, 9, 0, 3, 0, KIND_RANGE, 0, 0));
    pending.push_back(mk(CMD_SET, 5, 0, 1, 9, 0, 0, 0, KIND_RANGE, 0, 0));
    pending.push_back(mk(CMD_SET, 6, 0, 1, 9, 0, 0, 0, 2'd3, 0, 0));
    for (int i = 0; i < 6; i++) pending.push_back(mk(CMD_TICK, 31, 31, 16'hFFFF,
        16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 2'd3, 1, 1));
    for (int a = 0; a < 7; a++) begin
      pending.push_back(mk(CMD_QUERY, 5'(a), 0, 0, 0, 0, 0, 0, 0, 0, 1));
      pending.push_back(mk(CMD_QUERY, 5'(a), 0, 0, 0, 0, 0, 0, 0, 0, 0));
    end
    for (int i = 0; i < 1000; i++) begin
      if (i % 40 == 0) begin
        // well-formed sequence on a random channel
        int a, n;
        a = $urandom_range(0, 5);
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          pending.push_back(mk(CMD_WRITE, 5'(a), 5'(k), 16'($urandom), 0, 1'($urandom),
                               16'($urandom_range(1, 4)), 16'($urandom_range(4, 9)),
                               0, 0, 0));
        pending.push_back(mk(CMD_SET, 5'(a), 5'(n), 0, 0, 0, 0, 0, KIND_SEQ,
                             1'($urandom), 0));
      end
      pending.push_back(rand_word());
    end
    wait (accepted > 300);
    hold_off = 200;
    wait (accepted > 700);
    pause_send = 1;
    wait (expected.size() == 0 && !in_valid_i);
    repeat (200) @(posedge clk_i);
    pause_send = 0;
    wait (pending.size() == 0 && !in_valid_i);
    wait (expected.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
